// ===== rtl/rspe_pkg.sv =====
// ----------------------------------------------------------------------------
// Register server PDU engine package
// Function codes, exception reasons, limits and header positions.
// ----------------------------------------------------------------------------
package rspe_pkg;

    localparam int NUM_REGS_DEF = 256;
    localparam int REG_W        = 16;

    // Item operations
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Function codes
    localparam logic [7:0] FC_READ  = 8'h03;
    localparam logic [7:0] FC_WRITE = 8'h10;
    localparam logic [7:0] EXC_FLAG = 8'h80;

    // Register count limits
    localparam logic [15:0] MAX_READ  = 16'd125;
    localparam logic [15:0] MAX_WRITE = 16'd123;

    // Exception reasons
    localparam logic [1:0] EXC_NONE  = 2'd0;
    localparam logic [1:0] EXC_FUNC  = 2'd1;
    localparam logic [1:0] EXC_ADDR  = 2'd2;
    localparam logic [1:0] EXC_VALUE = 2'd3;

    // Request byte positions
    localparam logic [7:0] POS_FUNC     = 8'd0;
    localparam logic [7:0] POS_ADDR_HI  = 8'd1;
    localparam logic [7:0] POS_ADDR_LO  = 8'd2;
    localparam logic [7:0] POS_CNT_HI   = 8'd3;
    localparam logic [7:0] POS_CNT_LO   = 8'd4;
    localparam logic [7:0] POS_BYTE_CNT = 8'd5;
    localparam logic [7:0] POS_DATA     = 8'd6;
    localparam logic [7:0] POS_SAT      = 8'd255;

    // Request lengths
    localparam logic [8:0] READ_HDR_LEN  = 9'd5;
    localparam logic [8:0] WRITE_HDR_LEN = 9'd6;

    // Write reply: last byte position
    localparam logic [16:0] WRITE_REPLY_LAST = 17'd4;

endpackage

// ===== rtl/rspe_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one push or fetch item per beat.
// ----------------------------------------------------------------------------
interface rspe_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] req_byte;
    logic       req_last;

    modport source (output valid, output operation, output req_byte, output req_last,
                    input ready);
    modport sink   (input valid, input operation, input req_byte, input req_last,
                    output ready);
endinterface

// ===== rtl/rspe_resp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one response byte per beat.
// ----------------------------------------------------------------------------
interface rspe_resp_if;
    logic       valid;
    logic       ready;
    logic [7:0] resp_byte;
    logic       resp_last;
    logic       resp_valid;

    modport source (output valid, output resp_byte, output resp_last, output resp_valid,
                    input ready);
    modport sink   (input valid, input resp_byte, input resp_last, input resp_valid,
                    output ready);
endinterface

// ===== rtl/rspe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered and held without re.
// ----------------------------------------------------------------------------
module rspe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/register_server_pdu_engine_top.sv =====
// ----------------------------------------------------------------------------
// Register server PDU engine
// Server side of the holding-register PDU: read registers and write multiple.
// ----------------------------------------------------------------------------
// Each req beat is either a push of one request byte (operation 0) or a fetch
// of the next response byte (operation 1); every fetch yields exactly one resp
// beat, with resp_valid low when no response is pending, and pushes yield none.
// A new item can be taken every cycle while req.ready is high. The resp
// beat for a fetch shows up in the cycle after acceptance. A fetch that returns
// register data issues its read to the holding-register RAM at acceptance, and
// the byte is muxed onto resp straight from the RAM's registered read, in step
// with the output register that carries the other fields. After the clear pass,
// fetches stall only while that output register holds a beat that is not
// being taken; pushes never stall.
// After reset the block runs a clear pass over the register RAM, one entry per
// cycle, over all NUM_REGS entries (256 by default), with req.ready held low.
// Write-multiple data words land in the RAM as their low byte arrives, so a
// following read sees them with no extra wait.
// ----------------------------------------------------------------------------
module register_server_pdu_engine_top #(
    parameter int NUM_REGS = rspe_pkg::NUM_REGS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rspe_req_if.sink    req,
    rspe_resp_if.source resp
);

    localparam int           AW         = $clog2(NUM_REGS);
    localparam logic [16:0]  NUM_REGS_W = 17'(NUM_REGS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_REGS - 1);

    // Request parse state
    logic [7:0]  byte_pos_reg,   byte_pos_next;
    logic [7:0]  func_code_reg,  func_code_next;
    logic [15:0] start_addr_reg, start_addr_next;
    logic [15:0] reg_count_reg,  reg_count_next;
    logic [7:0]  high_hold_reg,  high_hold_next;
    logic [1:0]  exc_reg,        exc_next;
    logic        resp_pend_reg,  resp_pend_next;
    logic [7:0]  resp_pos_reg,   resp_pos_next;

    // Output beat register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg,   out_byte_next;
    logic        out_last_reg,   out_last_next;
    logic        out_rvalid_reg, out_rvalid_next;
    logic        out_mem_reg,    out_mem_next;
    logic        out_lo_reg,     out_lo_next;

    // Clear pass after reset
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // Handshake
    logic accept;
    logic push;
    logic fetch;

    // Push path
    logic [7:0]  wr_k;
    logic [16:0] wr_sum;
    logic [16:0] hdr_sum;
    logic [16:0] fin_sum;
    logic [8:0]  rcvd;
    logic        push_we;
    logic [AW-1:0] push_waddr;

    // Fetch path
    logic [7:0]  rd_k;
    logic [16:0] rd_sum;
    logic [16:0] final_pos;
    logic        fetch_re;

    // RAM port
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [rspe_pkg::REG_W-1:0] ram_wdata;
    logic [rspe_pkg::REG_W-1:0] ram_rdata;

    // After clearing, pushes any time; a fetch only when the output slot frees up
    assign req.ready = !clr_busy_reg &&
                       ((req.operation == rspe_pkg::OP_PUSH) || !out_valid_reg || resp.ready);
    assign accept    = req.valid && req.ready;
    assign push      = accept && (req.operation == rspe_pkg::OP_PUSH);
    assign fetch     = accept && (req.operation == rspe_pkg::OP_FETCH);

    // ------------------------------------------------------------------------
    // Push: parse header, check counts, store data words, close the request
    // ------------------------------------------------------------------------
    assign wr_k    = byte_pos_reg - rspe_pkg::POS_DATA;
    assign wr_sum  = {1'b0, start_addr_reg} + 17'(wr_k[7:1]);
    assign hdr_sum = {1'b0, start_addr_reg} + {1'b0, reg_count_reg};
    assign fin_sum = {1'b0, start_addr_next} + {1'b0, reg_count_next};
    assign rcvd    = {1'b0, byte_pos_reg} + 9'd1;

    always_comb
    begin
        byte_pos_next   = byte_pos_reg;
        func_code_next  = func_code_reg;
        start_addr_next = start_addr_reg;
        reg_count_next  = reg_count_reg;
        high_hold_next  = high_hold_reg;
        exc_next        = exc_reg;
        resp_pend_next  = resp_pend_reg;
        resp_pos_next   = resp_pos_reg;
        push_we         = 1'b0;
        push_waddr      = wr_sum[AW-1:0];

        out_byte_next   = 8'd0;
        out_last_next   = 1'b0;
        out_rvalid_next = 1'b0;
        out_mem_next    = 1'b0;
        out_lo_next     = 1'b0;
        fetch_re        = 1'b0;
        final_pos       = 17'd0;

        if (push)
        begin
            // drop any response still pending
            resp_pend_next = 1'b0;
            resp_pos_next  = 8'd0;
            case (byte_pos_reg)
                rspe_pkg::POS_FUNC:
                begin
                    func_code_next  = req.req_byte;
                    exc_next        = rspe_pkg::EXC_NONE;
                    start_addr_next = 16'd0;
                    reg_count_next  = 16'd0;
                end
                rspe_pkg::POS_ADDR_HI: start_addr_next = {req.req_byte, start_addr_reg[7:0]};
                rspe_pkg::POS_ADDR_LO: start_addr_next = {start_addr_reg[15:8], req.req_byte};
                rspe_pkg::POS_CNT_HI:  reg_count_next  = {req.req_byte, reg_count_reg[7:0]};
                rspe_pkg::POS_CNT_LO:  reg_count_next  = {reg_count_reg[15:8], req.req_byte};
                default:
                begin
                    if (func_code_reg == rspe_pkg::FC_WRITE)
                    begin
                        if (byte_pos_reg == rspe_pkg::POS_BYTE_CNT)
                        begin
                            if (reg_count_reg == 16'd0 || reg_count_reg > rspe_pkg::MAX_WRITE ||
                                {9'd0, req.req_byte} != {reg_count_reg, 1'b0})
                            begin
                                exc_next = rspe_pkg::EXC_VALUE;
                            end
                            else if (hdr_sum > NUM_REGS_W)
                            begin
                                exc_next = rspe_pkg::EXC_ADDR;
                            end
                            else
                            begin
                                exc_next = rspe_pkg::EXC_NONE;
                            end
                        end
                        else if (exc_reg == rspe_pkg::EXC_NONE &&
                                 {9'd0, wr_k} < {reg_count_reg, 1'b0})
                        begin
                            if (!wr_k[0])
                            begin
                                high_hold_next = req.req_byte;
                            end
                            else if (wr_sum < NUM_REGS_W)
                            begin
                                push_we = 1'b1;
                            end
                        end
                    end
                end
            endcase

            if (req.req_last)
            begin
                // close the request and arm the response
                if (func_code_next == rspe_pkg::FC_READ)
                begin
                    if (rcvd < rspe_pkg::READ_HDR_LEN || reg_count_next == 16'd0 ||
                        reg_count_next > rspe_pkg::MAX_READ)
                    begin
                        exc_next = rspe_pkg::EXC_VALUE;
                    end
                    else if (fin_sum > NUM_REGS_W)
                    begin
                        exc_next = rspe_pkg::EXC_ADDR;
                    end
                    else
                    begin
                        exc_next = rspe_pkg::EXC_NONE;
                    end
                end
                else if (func_code_next == rspe_pkg::FC_WRITE)
                begin
                    if (rcvd < rspe_pkg::WRITE_HDR_LEN)
                    begin
                        exc_next = rspe_pkg::EXC_VALUE;
                    end
                    else if (exc_next == rspe_pkg::EXC_NONE &&
                             {9'd0, rcvd} <
                             18'({reg_count_next, 1'b0}) + 18'(rspe_pkg::WRITE_HDR_LEN))
                    begin
                        exc_next = rspe_pkg::EXC_VALUE;
                    end
                end
                else
                begin
                    exc_next = rspe_pkg::EXC_FUNC;
                end
                resp_pend_next = 1'b1;
                resp_pos_next  = 8'd0;
                byte_pos_next  = 8'd0;
            end
            else if (byte_pos_reg != rspe_pkg::POS_SAT)
            begin
                byte_pos_next = byte_pos_reg + 8'd1;
            end
        end
        else if (fetch && resp_pend_reg)
        begin
            out_rvalid_next = 1'b1;
            if (exc_reg != rspe_pkg::EXC_NONE)
            begin
                final_pos     = 17'd1;
                out_byte_next = (resp_pos_reg == 8'd0) ? rspe_pkg::EXC_FLAG + func_code_reg
                                                       : {6'd0, exc_reg};
            end
            else if (func_code_reg == rspe_pkg::FC_READ)
            begin
                final_pos = {reg_count_reg, 1'b1};
                if (resp_pos_reg == 8'd0)
                begin
                    out_byte_next = rspe_pkg::FC_READ;
                end
                else if (resp_pos_reg == 8'd1)
                begin
                    out_byte_next = {reg_count_reg[6:0], 1'b0};
                end
                else
                begin
                    // register byte comes from the RAM's registered read
                    fetch_re     = 1'b1;
                    out_mem_next = 1'b1;
                    out_lo_next  = rd_k[0];
                end
            end
            else
            begin
                final_pos = rspe_pkg::WRITE_REPLY_LAST;
                case (resp_pos_reg)
                    8'd0:    out_byte_next = rspe_pkg::FC_WRITE;
                    8'd1:    out_byte_next = start_addr_reg[15:8];
                    8'd2:    out_byte_next = start_addr_reg[7:0];
                    8'd3:    out_byte_next = reg_count_reg[15:8];
                    default: out_byte_next = reg_count_reg[7:0];
                endcase
            end
            out_last_next = ({9'd0, resp_pos_reg} >= final_pos);
            if (out_last_next)
            begin
                resp_pend_next = 1'b0;
                resp_pos_next  = 8'd0;
            end
            else
            begin
                resp_pos_next = resp_pos_reg + 8'd1;
            end
        end
    end

    assign rd_k   = resp_pos_reg - 8'd2;
    assign rd_sum = {1'b0, start_addr_reg} + 17'(rd_k[7:1]);

    // ------------------------------------------------------------------------
    // Holding-register store
    // ------------------------------------------------------------------------
    assign ram_we    = clr_busy_reg || push_we;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : push_waddr;
    assign ram_wdata = clr_busy_reg ? '0 : {high_hold_reg, req.req_byte};

    rspe_ram #(
        .WIDTH (rspe_pkg::REG_W),
        .DEPTH (NUM_REGS)
    ) u_regs (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (fetch_re),
        .raddr (rd_sum[AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg   <= 8'd0;
            func_code_reg  <= 8'd0;
            start_addr_reg <= 16'd0;
            reg_count_reg  <= 16'd0;
            high_hold_reg  <= 8'd0;
            exc_reg        <= rspe_pkg::EXC_NONE;
            resp_pend_reg  <= 1'b0;
            resp_pos_reg   <= 8'd0;
            out_valid_reg  <= 1'b0;
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            byte_pos_reg   <= byte_pos_next;
            func_code_reg  <= func_code_next;
            start_addr_reg <= start_addr_next;
            reg_count_reg  <= reg_count_next;
            high_hold_reg  <= high_hold_next;
            exc_reg        <= exc_next;
            resp_pend_reg  <= resp_pend_next;
            resp_pos_reg   <= resp_pos_next;

            if (fetch)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (clr_busy_reg)
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_busy_reg <= 1'b0;
                end
                else
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                end
            end
        end
    end

    // Output payload holds while the beat waits
    always_ff @(posedge clk)
    begin
        if (fetch)
        begin
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
            out_rvalid_reg <= out_rvalid_next;
            out_mem_reg    <= out_mem_next;
            out_lo_reg     <= out_lo_next;
        end
    end

    assign resp.valid      = out_valid_reg;
    assign resp.resp_byte  = out_mem_reg ? (out_lo_reg ? ram_rdata[7:0] : ram_rdata[15:8])
                                         : out_byte_reg;
    assign resp.resp_last  = out_last_reg;
    assign resp.resp_valid = out_rvalid_reg;

`ifndef SYNTHESIS
    // No item enters while the store is being cleared
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !req.ready)
        else $error("item accepted during clear pass");

    // Data words land only for a write request that passed its checks
    a_write_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !clr_busy_reg) |->
            (push && func_code_reg == rspe_pkg::FC_WRITE && exc_reg == rspe_pkg::EXC_NONE))
        else $error("register write outside a checked write request");

    // A response position only advances while a response is pending
    a_pos_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_pos_reg != 8'd0) |-> resp_pend_reg)
        else $error("response position without pending response");
`endif

endmodule
